### sv/gtl_pkg.sv
// Shared types, character codes and the transliteration table for the transliterator.
package gtl_pkg;

	// One table entry: how many Latin bytes a code gives, and the bytes themselves.
	typedef struct packed {
		logic [7:0] code;
		logic [1:0] len;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
	} gtl_ent_t;

	// Held nasal letter codes.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MU_UP = 3'd1;
	localparam logic [2:0] ST_MU_LO = 3'd2;
	localparam logic [2:0] ST_NU_UP = 3'd3;
	localparam logic [2:0] ST_NU_LO = 3'd4;

	// Greek codes with special handling.
	localparam logic [7:0] CODE_MU_UP  = 8'd204;
	localparam logic [7:0] CODE_MU_LO  = 8'd236;
	localparam logic [7:0] CODE_NU_UP  = 8'd205;
	localparam logic [7:0] CODE_NU_LO  = 8'd237;
	localparam logic [7:0] CODE_PI_UP  = 8'd208;
	localparam logic [7:0] CODE_PI_LO  = 8'd240;
	localparam logic [7:0] CODE_TAU_UP = 8'd212;
	localparam logic [7:0] CODE_TAU_LO = 8'd244;

	// Latin replacements for the nasal clusters.
	localparam logic [7:0] CHR_B_UP = 8'd66;
	localparam logic [7:0] CHR_B_LO = 8'd98;
	localparam logic [7:0] CHR_D_UP = 8'd68;
	localparam logic [7:0] CHR_D_LO = 8'd100;

	// Builds one entry from its byte list.
	function automatic gtl_ent_t mk(input logic [7:0] code, input logic [1:0] len,
			input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2);
		gtl_ent_t e;
		e.code = code;
		e.len  = len;
		e.c0   = c0;
		e.c1   = c1;
		e.c2   = c2;
		return e;
	endfunction

	// Transliteration table; codes without an entry pass through as one byte.
	function automatic gtl_ent_t xlat(input logic [7:0] b);
		gtl_ent_t e;
		unique case (b)
			8'd168: e = mk(b, 2'd1, 8'd34, 8'd0, 8'd0);
			8'd180: e = mk(b, 2'd1, 8'd39, 8'd0, 8'd0);
			8'd181: e = mk(b, 2'd2, 8'd39, 8'd34, 8'd0);
			8'd182: e = mk(b, 2'd1, 8'd39, 8'd0, 8'd0);
			8'd184: e = mk(b, 2'd2, 8'd39, 8'd69, 8'd0);
			8'd185: e = mk(b, 2'd2, 8'd39, 8'd72, 8'd0);
			8'd186: e = mk(b, 2'd2, 8'd39, 8'd73, 8'd0);
			8'd188: e = mk(b, 2'd2, 8'd39, 8'd79, 8'd0);
			8'd190: e = mk(b, 2'd2, 8'd39, 8'd89, 8'd0);
			8'd191: e = mk(b, 2'd2, 8'd39, 8'd87, 8'd0);
			8'd192: e = mk(b, 2'd3, 8'd105, 8'd34, 8'd39);
			8'd193: e = mk(b, 2'd1, 8'd65, 8'd0, 8'd0);
			8'd194: e = mk(b, 2'd1, 8'd86, 8'd0, 8'd0);
			8'd195: e = mk(b, 2'd1, 8'd71, 8'd0, 8'd0);
			8'd196: e = mk(b, 2'd1, 8'd68, 8'd0, 8'd0);
			8'd197: e = mk(b, 2'd1, 8'd69, 8'd0, 8'd0);
			8'd198: e = mk(b, 2'd1, 8'd90, 8'd0, 8'd0);
			8'd199: e = mk(b, 2'd1, 8'd72, 8'd0, 8'd0);
			8'd200: e = mk(b, 2'd1, 8'd56, 8'd0, 8'd0);
			8'd201: e = mk(b, 2'd1, 8'd73, 8'd0, 8'd0);
			8'd202: e = mk(b, 2'd1, 8'd75, 8'd0, 8'd0);
			8'd203: e = mk(b, 2'd1, 8'd76, 8'd0, 8'd0);
			8'd204: e = mk(b, 2'd1, 8'd77, 8'd0, 8'd0);
			8'd205: e = mk(b, 2'd1, 8'd78, 8'd0, 8'd0);
			8'd206: e = mk(b, 2'd2, 8'd75, 8'd83, 8'd0);
			8'd207: e = mk(b, 2'd1, 8'd79, 8'd0, 8'd0);
			8'd208: e = mk(b, 2'd1, 8'd80, 8'd0, 8'd0);
			8'd209: e = mk(b, 2'd1, 8'd82, 8'd0, 8'd0);
			8'd211: e = mk(b, 2'd1, 8'd83, 8'd0, 8'd0);
			8'd212: e = mk(b, 2'd1, 8'd84, 8'd0, 8'd0);
			8'd213: e = mk(b, 2'd1, 8'd89, 8'd0, 8'd0);
			8'd214: e = mk(b, 2'd1, 8'd70, 8'd0, 8'd0);
			8'd215: e = mk(b, 2'd1, 8'd88, 8'd0, 8'd0);
			8'd216: e = mk(b, 2'd2, 8'd80, 8'd83, 8'd0);
			8'd217: e = mk(b, 2'd1, 8'd87, 8'd0, 8'd0);
			8'd218: e = mk(b, 2'd2, 8'd34, 8'd73, 8'd0);
			8'd219: e = mk(b, 2'd2, 8'd34, 8'd89, 8'd0);
			8'd220: e = mk(b, 2'd2, 8'd97, 8'd39, 8'd0);
			8'd221: e = mk(b, 2'd2, 8'd101, 8'd39, 8'd0);
			8'd222: e = mk(b, 2'd2, 8'd104, 8'd39, 8'd0);
			8'd223: e = mk(b, 2'd2, 8'd105, 8'd39, 8'd0);
			8'd224: e = mk(b, 2'd3, 8'd121, 8'd34, 8'd39);
			8'd225: e = mk(b, 2'd1, 8'd97, 8'd0, 8'd0);
			8'd226: e = mk(b, 2'd1, 8'd118, 8'd0, 8'd0);
			8'd227: e = mk(b, 2'd1, 8'd103, 8'd0, 8'd0);
			8'd228: e = mk(b, 2'd1, 8'd100, 8'd0, 8'd0);
			8'd229: e = mk(b, 2'd1, 8'd101, 8'd0, 8'd0);
			8'd230: e = mk(b, 2'd1, 8'd122, 8'd0, 8'd0);
			8'd231: e = mk(b, 2'd1, 8'd104, 8'd0, 8'd0);
			8'd232: e = mk(b, 2'd1, 8'd56, 8'd0, 8'd0);
			8'd233: e = mk(b, 2'd1, 8'd105, 8'd0, 8'd0);
			8'd234: e = mk(b, 2'd1, 8'd107, 8'd0, 8'd0);
			8'd235: e = mk(b, 2'd1, 8'd108, 8'd0, 8'd0);
			8'd236: e = mk(b, 2'd1, 8'd109, 8'd0, 8'd0);
			8'd237: e = mk(b, 2'd1, 8'd110, 8'd0, 8'd0);
			8'd238: e = mk(b, 2'd2, 8'd107, 8'd115, 8'd0);
			8'd239: e = mk(b, 2'd1, 8'd111, 8'd0, 8'd0);
			8'd240: e = mk(b, 2'd1, 8'd112, 8'd0, 8'd0);
			8'd241: e = mk(b, 2'd1, 8'd114, 8'd0, 8'd0);
			8'd242: e = mk(b, 2'd1, 8'd115, 8'd0, 8'd0);
			8'd243: e = mk(b, 2'd1, 8'd115, 8'd0, 8'd0);
			8'd244: e = mk(b, 2'd1, 8'd116, 8'd0, 8'd0);
			8'd245: e = mk(b, 2'd1, 8'd121, 8'd0, 8'd0);
			8'd246: e = mk(b, 2'd1, 8'd102, 8'd0, 8'd0);
			8'd247: e = mk(b, 2'd1, 8'd120, 8'd0, 8'd0);
			8'd248: e = mk(b, 2'd2, 8'd112, 8'd115, 8'd0);
			8'd249: e = mk(b, 2'd1, 8'd119, 8'd0, 8'd0);
			8'd250: e = mk(b, 2'd2, 8'd105, 8'd34, 8'd0);
			8'd251: e = mk(b, 2'd2, 8'd121, 8'd34, 8'd0);
			8'd252: e = mk(b, 2'd2, 8'd111, 8'd39, 8'd0);
			8'd253: e = mk(b, 2'd2, 8'd121, 8'd39, 8'd0);
			8'd254: e = mk(b, 2'd2, 8'd119, 8'd39, 8'd0);
			default: e = mk(b, 2'd1, b, 8'd0, 8'd0);
		endcase
		return e;
	endfunction

	// Held letter code for a nasal input byte, idle for anything else.
	function automatic logic [2:0] nasal_of(input logic [7:0] b);
		logic [2:0] s;
		unique case (b)
			CODE_MU_UP: s = ST_MU_UP;
			CODE_MU_LO: s = ST_MU_LO;
			CODE_NU_UP: s = ST_NU_UP;
			CODE_NU_LO: s = ST_NU_LO;
			default:    s = ST_IDLE;
		endcase
		return s;
	endfunction

	// Latin letter written when a held nasal is flushed.
	function automatic logic [7:0] flush_of(input logic [2:0] s);
		logic [7:0] c;
		unique case (s)
			ST_MU_UP: c = 8'd77;
			ST_MU_LO: c = 8'd109;
			ST_NU_UP: c = 8'd78;
			ST_NU_LO: c = 8'd110;
			default:  c = 8'd0;
		endcase
		return c;
	endfunction

endpackage

### sv/gtl_lookup.sv
// Input stage: registers the accepted item together with its synchronous table read.
module gtl_lookup (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              take,
	output logic              valid_s1,
	output gtl_pkg::gtl_ent_t ent_s1
);

	// The stage frees up when the sequencer takes its item.
	assign in_ready = !valid_s1 || take;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Table read, data registered with the item.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ent_s1 <= gtl_pkg::xlat(in_byte);
		end
	end

endmodule

### sv/gtl_emit.sv
// Output sequencer: resolves held nasals and streams up to four bytes, one per cycle while out_ready is high.
module gtl_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  gtl_pkg::gtl_ent_t ent_s1,
	output logic              take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              last
);

	logic [2:0] pend_q;
	logic [2:0] len_q;
	logic [1:0] ptr_q;
	logic [7:0] buf_q [4];

	logic [2:0] cur;
	logic [2:0] nx;
	logic [2:0] new_len;
	logic [2:0] new_pend;
	logic [7:0] seq [4];
	logic       fin;
	logic       out_fire;

	// Output handshake and end of the current sequence.
	assign out_valid = (len_q != 3'd0);
	assign out_byte  = buf_q[ptr_q];
	assign last      = ({1'b0, ptr_q} == (len_q - 3'd1));
	assign out_fire  = out_valid && out_ready;
	assign fin       = out_fire && last;
	assign take      = valid_s1 && (!out_valid || fin);

	// Work out the byte sequence and the next held letter for the waiting item.
	always_comb begin
		cur      = (pend_q > gtl_pkg::ST_NU_LO) ? gtl_pkg::ST_IDLE : pend_q;
		nx       = gtl_pkg::nasal_of(ent_s1.code);
		new_pend = gtl_pkg::ST_IDLE;
		new_len  = {1'b0, ent_s1.len};
		seq[0]   = ent_s1.c0;
		seq[1]   = ent_s1.c1;
		seq[2]   = ent_s1.c2;
		seq[3]   = 8'd0;
		if (cur == gtl_pkg::ST_IDLE) begin
			if (nx != gtl_pkg::ST_IDLE) begin
				new_len  = 3'd0;
				new_pend = nx;
			end
		end else if (nx != gtl_pkg::ST_IDLE) begin
			new_len  = 3'd1;
			seq[0]   = gtl_pkg::flush_of(cur);
			new_pend = nx;
		end else if ((cur == gtl_pkg::ST_MU_UP || cur == gtl_pkg::ST_MU_LO) &&
				(ent_s1.code == gtl_pkg::CODE_PI_UP || ent_s1.code == gtl_pkg::CODE_PI_LO)) begin
			new_len = 3'd1;
			seq[0]  = (cur == gtl_pkg::ST_MU_UP) ? gtl_pkg::CHR_B_UP : gtl_pkg::CHR_B_LO;
		end else if ((cur == gtl_pkg::ST_NU_UP || cur == gtl_pkg::ST_NU_LO) &&
				(ent_s1.code == gtl_pkg::CODE_TAU_UP ||
				ent_s1.code == gtl_pkg::CODE_TAU_LO)) begin
			new_len = 3'd1;
			seq[0]  = (cur == gtl_pkg::ST_NU_UP) ? gtl_pkg::CHR_D_UP : gtl_pkg::CHR_D_LO;
		end else begin
			new_len = {1'b0, ent_s1.len} + 3'd1;
			seq[0]  = gtl_pkg::flush_of(cur);
			seq[1]  = ent_s1.c0;
			seq[2]  = ent_s1.c1;
			seq[3]  = ent_s1.c2;
		end
	end

	// Sequence length, read pointer and held letter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= gtl_pkg::ST_IDLE;
			len_q  <= 3'd0;
			ptr_q  <= 2'd0;
		end else if (take) begin
			pend_q <= new_pend;
			len_q  <= new_len;
			ptr_q  <= 2'd0;
		end else if (out_fire) begin
			if (fin) begin
				len_q <= 3'd0;
			end else begin
				ptr_q <= ptr_q + 2'd1;
			end
		end
	end

	// Byte buffer for the sequence being sent.
	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= seq;
		end
	end

endmodule

### sv/greek_to_latin_transliterator.sv
// Top level of the ISO-8859-7 to Latin transliterator.
//
//  channel   handshake             payload
//  input     in_valid / in_ready   in_byte
//  output    out_valid / out_ready out_byte, last
//
// An item passes through the table read stage and then sends zero to four bytes,
// one per cycle while out_ready is high; a held nasal only updates the held letter,
// sends no byte and leaves the output idle. The first byte passes through the table
// read register and then the output buffer. The output buffer sets the rate, and a
// new item is read from the table while the previous item's bytes are still sent.
// Reset clears the held letter and both stage valid flags; a stall on the output holds
// the current byte and, once the input stage is full, backs up the input.
module greek_to_latin_transliterator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last
);

	logic              valid_s1;
	logic              take;
	gtl_pkg::gtl_ent_t ent_s1;

	// Table read stage.
	gtl_lookup u_lookup (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.take     (take),
		.valid_s1 (valid_s1),
		.ent_s1   (ent_s1)
	);

	// Nasal resolution and byte output.
	gtl_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ent_s1    (ent_s1),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

### sv/gtl_checker.sv
// Port level checks for the transliterator, bound to the top level.
module gtl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       last
);

	// A stalled output byte holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output item changed while stalled");

	// A waiting input item holds until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_byte))
		else $error("input item changed while waiting");

	// A nasal code never leaves the block untranslated.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_byte != gtl_pkg::CODE_MU_UP && out_byte != gtl_pkg::CODE_MU_LO &&
			out_byte != gtl_pkg::CODE_NU_UP && out_byte != gtl_pkg::CODE_NU_LO))
		else $error("raw nasal code on the output");

	// Output starting from empty follows an accepted item.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("output appeared without an accepted item");

	// Nothing but a final byte may end the output stream before a fresh input.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("sequence ended without its final byte");

endmodule

bind greek_to_latin_transliterator gtl_checker u_gtl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_byte   (in_byte),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last      (last)
);

### sim/tb_greek_to_latin_transliterator.sv
// Self-checking testbench for the Greek to Latin transliterator, with its scoreboard class.
module tb_greek_to_latin_transliterator;

	localparam int OPENING_ITEMS  = 25;
	localparam int RANDOM_ITEMS   = 155;
	localparam int LONG_HOLD      = 80;
	localparam int WATCHDOG_LIMIT = 400;
	localparam int TAIL_CYCLES    = 8;

	// Receiver stall patterns.
	localparam int RX_FREE    = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	// One Latin output byte as it should appear on the output channel.
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} latin_item_t;

	// Predicts the Latin bytes for each accepted Greek item and checks them in order.
	class translit_scoreboard;
		logic [2:0]  held_nasal;
		logic [7:0]  word_buf[$];
		latin_item_t latin_due[$];
		int          faults;

		function new();
			held_nasal = gtl_pkg::ST_IDLE;
			faults     = 0;
		endfunction

		function void flag(string msg);
			faults++;
			if (faults <= 10) begin
				$display("%s", msg);
			end
		endfunction

		// Spelling of one code, first byte in the top bits; unlisted codes pass through.
		function logic [23:0] latin_spelling(logic [7:0] g);
			logic [23:0] w;
			case (g)
				8'd168: w = {8'd34, 16'd0};            8'd180: w = {8'd39, 16'd0};
				8'd181: w = {8'd39, 8'd34, 8'd0};      8'd182: w = {8'd39, 16'd0};
				8'd184: w = {8'd39, 8'd69, 8'd0};      8'd185: w = {8'd39, 8'd72, 8'd0};
				8'd186: w = {8'd39, 8'd73, 8'd0};      8'd188: w = {8'd39, 8'd79, 8'd0};
				8'd190: w = {8'd39, 8'd89, 8'd0};      8'd191: w = {8'd39, 8'd87, 8'd0};
				8'd192: w = {8'd105, 8'd34, 8'd39};    8'd193: w = {8'd65, 16'd0};
				8'd194: w = {8'd86, 16'd0};            8'd195: w = {8'd71, 16'd0};
				8'd196: w = {8'd68, 16'd0};            8'd197: w = {8'd69, 16'd0};
				8'd198: w = {8'd90, 16'd0};            8'd199: w = {8'd72, 16'd0};
				8'd200: w = {8'd56, 16'd0};            8'd201: w = {8'd73, 16'd0};
				8'd202: w = {8'd75, 16'd0};            8'd203: w = {8'd76, 16'd0};
				8'd204: w = {8'd77, 16'd0};            8'd205: w = {8'd78, 16'd0};
				8'd206: w = {8'd75, 8'd83, 8'd0};      8'd207: w = {8'd79, 16'd0};
				8'd208: w = {8'd80, 16'd0};            8'd209: w = {8'd82, 16'd0};
				8'd211: w = {8'd83, 16'd0};            8'd212: w = {8'd84, 16'd0};
				8'd213: w = {8'd89, 16'd0};            8'd214: w = {8'd70, 16'd0};
				8'd215: w = {8'd88, 16'd0};            8'd216: w = {8'd80, 8'd83, 8'd0};
				8'd217: w = {8'd87, 16'd0};            8'd218: w = {8'd34, 8'd73, 8'd0};
				8'd219: w = {8'd34, 8'd89, 8'd0};      8'd220: w = {8'd97, 8'd39, 8'd0};
				8'd221: w = {8'd101, 8'd39, 8'd0};     8'd222: w = {8'd104, 8'd39, 8'd0};
				8'd223: w = {8'd105, 8'd39, 8'd0};     8'd224: w = {8'd121, 8'd34, 8'd39};
				8'd225: w = {8'd97, 16'd0};            8'd226: w = {8'd118, 16'd0};
				8'd227: w = {8'd103, 16'd0};           8'd228: w = {8'd100, 16'd0};
				8'd229: w = {8'd101, 16'd0};           8'd230: w = {8'd122, 16'd0};
				8'd231: w = {8'd104, 16'd0};           8'd232: w = {8'd56, 16'd0};
				8'd233: w = {8'd105, 16'd0};           8'd234: w = {8'd107, 16'd0};
				8'd235: w = {8'd108, 16'd0};           8'd236: w = {8'd109, 16'd0};
				8'd237: w = {8'd110, 16'd0};           8'd238: w = {8'd107, 8'd115, 8'd0};
				8'd239: w = {8'd111, 16'd0};           8'd240: w = {8'd112, 16'd0};
				8'd241: w = {8'd114, 16'd0};           8'd242: w = {8'd115, 16'd0};
				8'd243: w = {8'd115, 16'd0};           8'd244: w = {8'd116, 16'd0};
				8'd245: w = {8'd121, 16'd0};           8'd246: w = {8'd102, 16'd0};
				8'd247: w = {8'd120, 16'd0};           8'd248: w = {8'd112, 8'd115, 8'd0};
				8'd249: w = {8'd119, 16'd0};           8'd250: w = {8'd105, 8'd34, 8'd0};
				8'd251: w = {8'd121, 8'd34, 8'd0};     8'd252: w = {8'd111, 8'd39, 8'd0};
				8'd253: w = {8'd121, 8'd39, 8'd0};     8'd254: w = {8'd119, 8'd39, 8'd0};
				default: w = {g, 16'd0};
			endcase
			return w;
		endfunction

		function logic [2:0] nasal_code(logic [7:0] g);
			case (g)
				gtl_pkg::CODE_MU_UP: return gtl_pkg::ST_MU_UP;
				gtl_pkg::CODE_MU_LO: return gtl_pkg::ST_MU_LO;
				gtl_pkg::CODE_NU_UP: return gtl_pkg::ST_NU_UP;
				gtl_pkg::CODE_NU_LO: return gtl_pkg::ST_NU_LO;
				default:             return gtl_pkg::ST_IDLE;
			endcase
		endfunction

		function logic [7:0] flush_letter(logic [2:0] s);
			case (s)
				gtl_pkg::ST_MU_UP: return 8'd77;
				gtl_pkg::ST_MU_LO: return 8'd109;
				gtl_pkg::ST_NU_UP: return 8'd78;
				default:           return 8'd110;
			endcase
		endfunction

		// The first byte always goes out, even a zero that passes through.
		function void spell(logic [7:0] g);
			logic [23:0] w;
			w = latin_spelling(g);
			word_buf.push_back(w[23:16]);
			if (w[15:8] != 8'd0) begin
				word_buf.push_back(w[15:8]);
			end
			if (w[7:0] != 8'd0) begin
				word_buf.push_back(w[7:0]);
			end
		endfunction

		// Works out the bytes caused by one accepted Greek item.
		function void note_greek(logic [7:0] g);
			logic [2:0]  cur;
			logic [2:0]  nx;
			latin_item_t li;
			cur = held_nasal;
			if (cur > gtl_pkg::ST_NU_LO) begin
				cur = gtl_pkg::ST_IDLE;
			end
			nx = nasal_code(g);
			word_buf.delete();
			if (cur == gtl_pkg::ST_IDLE) begin
				if (nx == gtl_pkg::ST_IDLE) begin
					spell(g);
				end
				held_nasal = nx;
			end else if (nx != gtl_pkg::ST_IDLE) begin
				// A nasal after a nasal releases the older one and holds the new one.
				word_buf.push_back(flush_letter(cur));
				held_nasal = nx;
			end else if ((cur == gtl_pkg::ST_MU_UP || cur == gtl_pkg::ST_MU_LO) &&
					(g == gtl_pkg::CODE_PI_UP || g == gtl_pkg::CODE_PI_LO)) begin
				word_buf.push_back(cur == gtl_pkg::ST_MU_UP ?
						gtl_pkg::CHR_B_UP : gtl_pkg::CHR_B_LO);
				held_nasal = gtl_pkg::ST_IDLE;
			end else if ((cur == gtl_pkg::ST_NU_UP || cur == gtl_pkg::ST_NU_LO) &&
					(g == gtl_pkg::CODE_TAU_UP || g == gtl_pkg::CODE_TAU_LO)) begin
				word_buf.push_back(cur == gtl_pkg::ST_NU_UP ?
						gtl_pkg::CHR_D_UP : gtl_pkg::CHR_D_LO);
				held_nasal = gtl_pkg::ST_IDLE;
			end else begin
				word_buf.push_back(flush_letter(cur));
				spell(g);
				held_nasal = gtl_pkg::ST_IDLE;
			end
			foreach (word_buf[i]) begin
				li.ch  = word_buf[i];
				li.fin = (i == word_buf.size() - 1);
				latin_due.push_back(li);
			end
		endfunction

		// Compares one accepted output byte with the oldest one still owed.
		function void check_latin(logic [7:0] ch, logic fin);
			latin_item_t want;
			if (latin_due.size() == 0) begin
				flag($sformatf("unexpected output byte %0d last %0b", ch, fin));
			end else begin
				want = latin_due.pop_front();
				if (ch !== want.ch || fin !== want.fin) begin
					flag($sformatf("output mismatch: expected byte %0d last %0b, got %0d last %0b",
							want.ch, want.fin, ch, fin));
				end
			end
		endfunction

		function void close_out();
			while (latin_due.size() != 0) begin
				flag($sformatf("output byte %0d never arrived", latin_due[0].ch));
				void'(latin_due.pop_front());
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       last;

	translit_scoreboard sb;
	int  burst_left;
	int  quiet_cycles;
	bit  hold_request;

	greek_to_latin_transliterator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one Greek item and waits until it is taken; bursts are broken by random gaps.
	task automatic send_greek(input logic [7:0] g);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte  <= g;
		do @(posedge clk); while (!in_ready);
	endtask

	// Stops offering items until every owed output byte has been seen.
	task automatic pause_sender();
		in_valid   <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.latin_due.size() != 0);
	endtask

	function automatic logic [7:0] any_nasal();
		case ($urandom_range(0, 3))
			0:       return gtl_pkg::CODE_MU_UP;
			1:       return gtl_pkg::CODE_MU_LO;
			2:       return gtl_pkg::CODE_NU_UP;
			default: return gtl_pkg::CODE_NU_LO;
		endcase
	endfunction

	// Receiver: switches between free running, random stalls and a fixed pattern,
	// with one long hold-off on request.
	initial begin
		int mode;
		int span;
		int phase;
		int hold;
		out_ready = 1'b0;
		mode  = RX_FREE;
		span  = 0;
		phase = 0;
		hold  = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold = LONG_HOLD;
			end
			if (span == 0) begin
				mode = $urandom_range(RX_FREE, RX_PATTERN);
				span = $urandom_range(8, 40);
			end
			span--;
			phase++;
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				case (mode)
					RX_FREE:   out_ready <= 1'b1;
					RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
					default:   out_ready <= (phase % 5) < 3;
				endcase
			end
		end
	end

	// Handshake monitor and watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_greek(in_byte);
			end
			if (out_valid && out_ready) begin
				sb.check_latin(out_byte, last);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Main sequence: directed text, then random text with one long stall and one drain.
	initial begin
		logic [7:0] opening_text [OPENING_ITEMS];
		logic [7:0] nas;
		int sent;
		int pick;
		bit hold_done;
		bit pause_done;
		opening_text = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd170, 8'd85, 8'd216, 8'd248,
				8'd192, 8'd224,
				gtl_pkg::CODE_MU_UP, gtl_pkg::CODE_PI_UP,
				gtl_pkg::CODE_MU_LO, gtl_pkg::CODE_PI_LO,
				gtl_pkg::CODE_NU_UP, gtl_pkg::CODE_TAU_UP,
				gtl_pkg::CODE_NU_LO, gtl_pkg::CODE_TAU_LO,
				gtl_pkg::CODE_MU_UP, gtl_pkg::CODE_NU_LO, gtl_pkg::CODE_PI_LO,
				gtl_pkg::CODE_MU_LO, 8'd192, gtl_pkg::CODE_NU_UP, 8'd65};
		sb = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_byte      = 8'd0;
		hold_request = 1'b0;
		burst_left   = 0;
		quiet_cycles = 0;
		hold_done    = 1'b0;
		pause_done   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: field extremes, both psi forms, the longest spellings, the four
		// same-case nasal clusters and several nasal flushes.
		foreach (opening_text[i]) begin
			send_greek(opening_text[i]);
		end
		pause_sender();

		// Random part: mostly Greek text and nasal clusters, some raw noise.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent >= 40 && !hold_done) begin
				hold_request = 1'b1;
				hold_done    = 1'b1;
			end
			if (sent >= 110 && !pause_done) begin
				pause_sender();
				pause_done = 1'b1;
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				send_greek(8'($urandom_range(0, 255)));
				sent += 1;
			end else if (pick < 45) begin
				nas = any_nasal();
				send_greek(nas);
				if ($urandom_range(0, 4) == 0) begin
					send_greek(8'($urandom_range(160, 255)));
				end else if (nas == gtl_pkg::CODE_MU_UP || nas == gtl_pkg::CODE_MU_LO) begin
					send_greek($urandom_range(0, 1) ?
							gtl_pkg::CODE_PI_UP : gtl_pkg::CODE_PI_LO);
				end else begin
					send_greek($urandom_range(0, 1) ?
							gtl_pkg::CODE_TAU_UP : gtl_pkg::CODE_TAU_LO);
				end
				sent += 2;
			end else if (pick < 55) begin
				send_greek(any_nasal());
				send_greek(any_nasal());
				sent += 2;
			end else begin
				send_greek(8'($urandom_range(160, 255)));
				sent += 1;
			end
		end

		pause_sender();
		repeat (TAIL_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.faults == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
